// ===== rtl/core/dnls_pkg.sv =====
// ----------------------------------------------------------------------------
// dnls_pkg
// Shared types, character codes and status codes of the decimal number scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package dnls_pkg;

  // result status codes
  localparam logic [1:0] ST_NUM = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_EOS = 2'd2;

  // character codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PT    = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [63:0] Mask60 = 64'h0fff_ffff_ffff_ffff;
  localparam logic [63:0] ExpCap = 64'h0000_0000_0000_3fff;

  // result queue depth
  localparam int QDepth = 4;

  typedef struct packed {
    logic [1:0]         status;
    logic               negative;
    logic [59:0]        integer_part;
    logic [59:0]        fraction_digits;
    logic [4:0]         fraction_length;
    logic signed [14:0] exponent;
    logic               saturated;
    logic               last;
  } res_t;

  // smaller of 10^digits-1 and cap, evaluated at elaboration
  function automatic logic [63:0] limit_of(input int digits, input logic [63:0] cap);
    logic [63:0] v;
    int          i;
    v = 64'd1;
    for (i = 0; i < digits && v <= cap; i++) begin
      v = v * 64'd10;
    end
    v = v - 64'd1;
    return (v < cap) ? v : cap;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dnls_scan.sv =====
// ----------------------------------------------------------------------------
// dnls_scan
// Scanner state and per-character step: up to two results per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dnls_scan #(
  parameter logic [63:0] INT_LIM = 64'd999999999999999999,
  parameter int          FRAC_DIGITS = 18,
  parameter logic [63:0] EXP_LIM = 64'd9999
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic [7:0]     char_code,
  input  wire logic           end_of_stream,
  output dnls_pkg::res_t      res0,
  output logic                res0_vld,
  output dnls_pkg::res_t      res1,
  output logic                res1_vld
);
  import dnls_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_LEADPT = 3'd2;
  localparam logic [2:0] PH_INT    = 3'd3;
  localparam logic [2:0] PH_FRAC   = 3'd4;
  localparam logic [2:0] PH_ESTART = 3'd5;
  localparam logic [2:0] PH_ESIGN  = 3'd6;
  localparam logic [2:0] PH_EDIG   = 3'd7;

  logic [2:0]  phase_r, phase_nxt;
  logic        sign_neg_r, sign_neg_nxt;
  logic [59:0] int_acc_r, int_acc_nxt;
  logic [59:0] frac_acc_r, frac_acc_nxt;
  logic [4:0]  frac_cnt_r, frac_cnt_nxt;
  logic        exp_neg_r, exp_neg_nxt;
  logic [13:0] exp_acc_r, exp_acc_nxt;
  logic        ovf_r, ovf_nxt;

  logic        dig, is_sp, is_sgn, is_e, is_pt;
  logic [3:0]  d;
  logic [63:0] int_mac, frac_mac;
  logic [17:0] exp_mac;
  logic        int_ok, frac_ok, exp_ok, exp_first_ok;
  logic        again, idle_first, idle_run;
  logic        r0_hit;
  logic [1:0]  r0_status;
  logic        idle_hit;
  logic [1:0]  idle_status;
  logic [14:0] exp_mag;

  assign dig    = !end_of_stream && (char_code >= CH_0) && (char_code <= CH_9);
  assign d      = dig ? 4'(char_code - CH_0) : 4'd0;
  assign is_sp  = (char_code == CH_SP) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
  assign is_sgn = !end_of_stream && ((char_code == CH_PLUS) || (char_code == CH_MINUS));
  assign is_e   = !end_of_stream && ((char_code == CH_E_LO) || (char_code == CH_E_UP));
  assign is_pt  = !end_of_stream && (char_code == CH_PT);

  // acc*10 + d as two shifted adds; compare against the saturation limit
  assign int_mac  = ({4'd0, int_acc_r} << 3) + ({4'd0, int_acc_r} << 1) + {60'd0, d};
  assign frac_mac = ({4'd0, frac_acc_r} << 3) + ({4'd0, frac_acc_r} << 1) + {60'd0, d};
  assign exp_mac  = ({4'd0, exp_acc_r} << 3) + ({4'd0, exp_acc_r} << 1) + {14'd0, d};
  assign int_ok       = int_mac <= INT_LIM;
  assign frac_ok      = (frac_cnt_r < 5'(FRAC_DIGITS)) && (frac_mac <= Mask60);
  assign exp_ok       = {46'd0, exp_mac} <= EXP_LIM;
  assign exp_first_ok = {60'd0, d} <= EXP_LIM;

  always_comb begin
    phase_nxt    = phase_r;
    sign_neg_nxt = sign_neg_r;
    int_acc_nxt  = int_acc_r;
    frac_acc_nxt = frac_acc_r;
    frac_cnt_nxt = frac_cnt_r;
    exp_neg_nxt  = exp_neg_r;
    exp_acc_nxt  = exp_acc_r;
    ovf_nxt      = ovf_r;
    again        = 1'b0;
    idle_first   = 1'b0;
    r0_hit       = 1'b0;
    r0_status    = ST_NUM;
    idle_hit     = 1'b0;
    idle_status  = ST_BAD;

    case (phase_r)
      PH_SIGN: begin
        if (dig) begin
          int_acc_nxt = {56'd0, d};
          phase_nxt   = PH_INT;
        end else if (is_pt) begin
          phase_nxt = PH_LEADPT;
        end else begin
          r0_hit = 1'b1; r0_status = ST_BAD; again = 1'b1;
        end
      end
      PH_LEADPT, PH_FRAC: begin
        if (dig) begin
          if (frac_ok) begin
            frac_acc_nxt = frac_mac[59:0];
            frac_cnt_nxt = frac_cnt_r + 5'd1;
          end else begin
            ovf_nxt = 1'b1;
          end
          phase_nxt = PH_FRAC;
        end else if (phase_r == PH_LEADPT) begin
          r0_hit = 1'b1; r0_status = ST_BAD; again = 1'b1;
        end else if (is_e) begin
          phase_nxt = PH_ESTART;
        end else begin
          r0_hit = 1'b1; r0_status = ST_NUM; again = 1'b1;
        end
      end
      PH_INT: begin
        if (dig) begin
          if (int_ok) begin
            int_acc_nxt = int_mac[59:0];
          end else begin
            int_acc_nxt = INT_LIM[59:0];
            ovf_nxt     = 1'b1;
          end
        end else if (is_pt) begin
          phase_nxt = PH_FRAC;
        end else if (is_e) begin
          phase_nxt = PH_ESTART;
        end else begin
          r0_hit = 1'b1; r0_status = ST_NUM; again = 1'b1;
        end
      end
      PH_ESTART, PH_ESIGN: begin
        if (dig) begin
          if (exp_first_ok) begin
            exp_acc_nxt = {10'd0, d};
          end else begin
            exp_acc_nxt = EXP_LIM[13:0];
            ovf_nxt     = 1'b1;
          end
          phase_nxt = PH_EDIG;
        end else if ((phase_r == PH_ESTART) && is_sgn) begin
          exp_neg_nxt = (char_code == CH_MINUS);
          phase_nxt   = PH_ESIGN;
        end else begin
          r0_hit = 1'b1; r0_status = ST_BAD; again = 1'b1;
        end
      end
      PH_EDIG: begin
        if (dig) begin
          if (exp_ok) begin
            exp_acc_nxt = exp_mac[13:0];
          end else begin
            exp_acc_nxt = EXP_LIM[13:0];
            ovf_nxt     = 1'b1;
          end
        end else begin
          r0_hit = 1'b1; r0_status = ST_NUM; again = 1'b1;
        end
      end
      default: begin
        idle_first = 1'b1;
      end
    endcase

    // idle pass on a cleared number: first pass in idle, or the rescan
    idle_run = again || idle_first;
    if (idle_run) begin
      phase_nxt    = PH_IDLE;
      sign_neg_nxt = 1'b0;
      int_acc_nxt  = '0;
      frac_acc_nxt = '0;
      frac_cnt_nxt = '0;
      exp_neg_nxt  = 1'b0;
      exp_acc_nxt  = '0;
      ovf_nxt      = 1'b0;
      if (end_of_stream) begin
        idle_hit = 1'b1; idle_status = ST_EOS;
      end else if (is_sp) begin
        idle_hit = 1'b0;
      end else if (is_sgn) begin
        sign_neg_nxt = (char_code == CH_MINUS);
        phase_nxt    = PH_SIGN;
      end else if (is_pt) begin
        phase_nxt = PH_LEADPT;
      end else if (dig) begin
        int_acc_nxt = {56'd0, d};
        phase_nxt   = PH_INT;
      end else begin
        idle_hit = 1'b1; idle_status = ST_BAD;
      end
    end
  end

  assign exp_mag = exp_neg_r ? (15'd0 - {1'b0, exp_acc_r}) : {1'b0, exp_acc_r};

  always_comb begin
    res0     = '0;
    res1     = '0;
    res0_vld = 1'b0;
    res1_vld = 1'b0;
    if (r0_hit) begin
      res0_vld      = 1'b1;
      res0.status   = r0_status;
      if (r0_status == ST_NUM) begin
        res0.negative        = sign_neg_r;
        res0.integer_part    = int_acc_r;
        res0.fraction_digits = frac_acc_r;
        res0.fraction_length = frac_cnt_r;
        res0.exponent        = exp_mag;
        res0.saturated       = ovf_r;
      end
      res1_vld    = idle_hit;
      res1.status = idle_status;
      res1.last   = 1'b1;
      res0.last   = !idle_hit;
    end else if (idle_hit) begin
      res0_vld    = 1'b1;
      res0.status = idle_status;
      res0.last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      sign_neg_r <= 1'b0;
      int_acc_r  <= '0;
      frac_acc_r <= '0;
      frac_cnt_r <= '0;
      exp_neg_r  <= 1'b0;
      exp_acc_r  <= '0;
      ovf_r      <= 1'b0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      sign_neg_r <= sign_neg_nxt;
      int_acc_r  <= int_acc_nxt;
      frac_acc_r <= frac_acc_nxt;
      frac_cnt_r <= frac_cnt_nxt;
      exp_neg_r  <= exp_neg_nxt;
      exp_acc_r  <= exp_acc_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    res1_vld |-> res0_vld)
    else $error("second result without first");

  a_rescan_not_number: assert property (@(posedge clk) disable iff (!rst_n)
    res1_vld |-> (res1.status == ST_BAD || res1.status == ST_EOS))
    else $error("rescan produced a number");

  a_eos_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && end_of_stream) |=> (phase_r == PH_IDLE))
    else $error("not idle after end of stream");

endmodule

`default_nettype wire

// ===== rtl/core/dnls_resq.sv =====
// ----------------------------------------------------------------------------
// dnls_resq
// Small result queue: takes up to two results per cycle, sends one per cycle while dout_rdy is high.
// ----------------------------------------------------------------------------
`default_nettype none

module dnls_resq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push0,
  input  wire dnls_pkg::res_t din0,
  input  wire logic           push1,
  input  wire dnls_pkg::res_t din1,
  output logic                room2,
  output logic                dout_vld,
  input  wire logic           dout_rdy,
  output dnls_pkg::res_t      dout
);
  import dnls_pkg::*;

  localparam int PW = $clog2(QDepth);
  localparam int CW = $clog2(QDepth + 1);

  res_t          q_r [QDepth];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;
  logic [PW-1:0] wr_ptr_p1;

  assign room2     = count_r <= CW'(QDepth - 2);
  assign dout_vld  = count_r != '0;
  assign dout      = q_r[rd_ptr_r];
  assign pop       = dout_vld && dout_rdy;
  assign wr_ptr_p1 = wr_ptr_r + PW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push0) + PW'(push1);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + CW'(push0) + CW'(push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      q_r[wr_ptr_r] <= din0;
    end
    if (push1) begin
      q_r[wr_ptr_p1] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QDepth))
    else $error("result queue count out of range");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> push0)
    else $error("second push without first");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push0 |-> room2)
    else $error("push into full result queue");

endmodule

`default_nettype wire

// ===== rtl/core/decimal_number_literal_scanner.sv =====
// ----------------------------------------------------------------------------
// decimal_number_literal_scanner
// Pulls decimal numbers out of a byte stream and reports their parts.
// ----------------------------------------------------------------------------
// One character is taken per clock while in_tready is high. Each character is
// resolved in the cycle it is accepted (multiply-by-ten and limit compare on the
// accumulators) and its results go into a four-entry result queue, so a finished
// result waiting on out_tready does not stop input. The output sends one result
// per cycle while out_tready is high: a character that both ends a number and
// gives a result of its own yields two results, and in_tready drops while fewer
// than two queue entries are free.
`default_nettype none

module decimal_number_literal_scanner #(
  parameter int INT_DIGITS  = 18,
  parameter int FRAC_DIGITS = 18,
  parameter int EXP_DIGITS  = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] char_code
  input  wire logic         in_tuser,   // [0] end_of_stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [0] negative, [60:1] integer_part, [120:61] fraction_digits,
  // [125:121] fraction_length, [140:126] exponent, [141] saturated, [143:142] 0
  output logic [143:0]      out_tdata,
  output logic [1:0]        out_tuser,  // [1:0] status
  output logic              out_tlast
);
  import dnls_pkg::*;

  localparam logic [63:0] IntLim = limit_of(INT_DIGITS, Mask60);
  localparam logic [63:0] ExpLim = limit_of(EXP_DIGITS, ExpCap);

  logic in_fire;
  res_t res0, res1, head;
  logic res0_vld, res1_vld;
  logic room2;

  assign in_fire = in_tvalid && in_tready;
  assign in_tready = room2;

  dnls_scan #(
    .INT_LIM     (IntLim),
    .FRAC_DIGITS (FRAC_DIGITS),
    .EXP_LIM     (ExpLim)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .char_code     (in_tdata),
    .end_of_stream (in_tuser),
    .res0          (res0),
    .res0_vld      (res0_vld),
    .res1          (res1),
    .res1_vld      (res1_vld)
  );

  dnls_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push0    (in_fire && res0_vld),
    .din0     (res0),
    .push1    (in_fire && res1_vld),
    .din1     (res1),
    .room2    (room2),
    .dout_vld (out_tvalid),
    .dout_rdy (out_tready),
    .dout     (head)
  );

  assign out_tdata = {2'b00, head.saturated, head.exponent, head.fraction_length,
                      head.fraction_digits, head.integer_part, head.negative};
  assign out_tuser = head.status;
  assign out_tlast = head.last;

endmodule

`default_nettype wire

// ===== tb/dnls_result_checker.sv =====
// ----------------------------------------------------------------------------
// dnls_result_checker
// Watches both stream channels of the decimal number scanner, works out the
// expected results of every accepted character and compares each result beat
// field by field against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module dnls_result_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] char_code
  input  logic         in_tuser,   // [0] end_of_stream
  input  logic         out_tvalid,
  input  logic         out_tready,
  // [0] negative, [60:1] integer_part, [120:61] fraction_digits,
  // [125:121] fraction_length, [140:126] exponent, [141] saturated, [143:142] 0
  input  logic [143:0] out_tdata,
  input  logic [1:0]   out_tuser,  // [1:0] status
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending,
  output int           results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import dnls_pkg::*;

  // limits for the default sizes: 18 integer/fraction digits, 4 exponent digits
  localparam logic [63:0] IntLimit   = 64'd999999999999999999;
  localparam logic [63:0] ExpLimit   = 64'd9999;
  localparam int          FracDigits = 18;

  typedef enum logic [2:0] {
    SC_IDLE, SC_SIGN, SC_LEADPT, SC_INT, SC_FRAC, SC_ESTART, SC_ESIGN, SC_EDIG
  } scan_phase_e;

  scan_phase_e scan_phase = SC_IDLE;
  logic        num_neg    = 1'b0;
  logic [63:0] int_value  = '0;
  logic [63:0] frac_value = '0;
  logic [4:0]  frac_len   = '0;
  logic        exp_neg    = 1'b0;
  logic [63:0] exp_value  = '0;
  logic        num_sat    = 1'b0;

  res_t expected_results [$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
  end

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_exp_mark(input logic [7:0] c);
    return (c == CH_E_LO) || (c == CH_E_UP);
  endfunction

  function automatic void clear_number();
    num_neg    = 1'b0;
    int_value  = '0;
    frac_value = '0;
    frac_len   = '0;
    exp_neg    = 1'b0;
    exp_value  = '0;
    num_sat    = 1'b0;
  endfunction

  // saturating acc*10+d
  function automatic logic [63:0] add_digit(input logic [63:0] acc, input logic [3:0] d,
                                            input logic [63:0] lim);
    logic [63:0] nv;
    if (acc > lim || acc > (lim - d) / 64'd10) begin
      num_sat = 1'b1;
      nv = lim;
    end else begin
      nv = acc * 64'd10 + d;
    end
    return nv;
  endfunction

  function automatic res_t close_number(input logic [1:0] st);
    res_t        r;
    logic [14:0] ev;
    r = '0;
    r.status = st;
    if (st == ST_NUM) begin
      ev = {1'b0, exp_value[13:0]};
      r.negative        = num_neg;
      r.integer_part    = int_value[59:0];
      r.fraction_digits = frac_value[59:0];
      r.fraction_length = frac_len;
      r.exponent        = exp_neg ? (15'd0 - ev) : ev;
      r.saturated       = num_sat;
    end
    clear_number();
    return r;
  endfunction

  task automatic predict_beat(input logic [7:0] c, input logic eos);
    logic       dig;
    logic [3:0] d;
    logic       again;
    int         n;
    int         i;
    res_t       found [2];
    dig = !eos && c >= CH_0 && c <= CH_9;
    d   = dig ? c[3:0] : 4'd0;
    n   = 0;
    do begin
      again = 1'b0;
      case (scan_phase)
        SC_IDLE: begin
          if (eos) begin
            found[n] = close_number(ST_EOS);
            n++;
          end else if (is_blank(c)) begin
          end else if (is_sign(c)) begin
            num_neg = (c == CH_MINUS);
            scan_phase = SC_SIGN;
          end else if (c == CH_PT) begin
            scan_phase = SC_LEADPT;
          end else if (dig) begin
            int_value = {60'd0, d};
            scan_phase = SC_INT;
          end else begin
            // stray character: reported and dropped
            found[n] = close_number(ST_BAD);
            n++;
          end
        end
        SC_SIGN: begin
          if (dig) begin
            int_value = {60'd0, d};
            scan_phase = SC_INT;
          end else if (!eos && c == CH_PT) begin
            scan_phase = SC_LEADPT;
          end else begin
            found[n] = close_number(ST_BAD);
            n++;
            scan_phase = SC_IDLE;
            again = 1'b1;
          end
        end
        SC_LEADPT, SC_FRAC: begin
          if (dig) begin
            if (frac_len < FracDigits && frac_value <= (Mask60 - d) / 64'd10) begin
              frac_value = frac_value * 64'd10 + d;
              frac_len = frac_len + 5'd1;
            end else begin
              num_sat = 1'b1;
            end
            scan_phase = SC_FRAC;
          end else if (scan_phase == SC_LEADPT) begin
            found[n] = close_number(ST_BAD);
            n++;
            scan_phase = SC_IDLE;
            again = 1'b1;
          end else if (!eos && is_exp_mark(c)) begin
            scan_phase = SC_ESTART;
          end else begin
            found[n] = close_number(ST_NUM);
            n++;
            scan_phase = SC_IDLE;
            again = 1'b1;
          end
        end
        SC_INT: begin
          if (dig) begin
            int_value = add_digit(int_value, d, IntLimit);
          end else if (!eos && c == CH_PT) begin
            scan_phase = SC_FRAC;
          end else if (!eos && is_exp_mark(c)) begin
            scan_phase = SC_ESTART;
          end else begin
            found[n] = close_number(ST_NUM);
            n++;
            scan_phase = SC_IDLE;
            again = 1'b1;
          end
        end
        SC_ESTART, SC_ESIGN: begin
          if (dig) begin
            exp_value = add_digit(64'd0, d, ExpLimit);
            scan_phase = SC_EDIG;
          end else if (scan_phase == SC_ESTART && !eos && is_sign(c)) begin
            exp_neg = (c == CH_MINUS);
            scan_phase = SC_ESIGN;
          end else begin
            found[n] = close_number(ST_BAD);
            n++;
            scan_phase = SC_IDLE;
            again = 1'b1;
          end
        end
        SC_EDIG: begin
          if (dig) begin
            exp_value = add_digit(exp_value, d, ExpLimit);
          end else begin
            found[n] = close_number(ST_NUM);
            n++;
            scan_phase = SC_IDLE;
            again = 1'b1;
          end
        end
        default: begin
          scan_phase = SC_IDLE;
          clear_number();
          again = 1'b1;
        end
      endcase
    end while (again && n < 2);
    if (n > 0) found[n-1].last = 1'b1;
    for (i = 0; i < n; i++) expected_results.push_back(found[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
             $realtime, results_checked, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    res_t seen;
    res_t want;
    if (!rst_n) begin
      scan_phase = SC_IDLE;
      clear_number();
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready) predict_beat(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        seen.status          = out_tuser;
        seen.negative        = out_tdata[0];
        seen.integer_part    = out_tdata[60:1];
        seen.fraction_digits = out_tdata[120:61];
        seen.fraction_length = out_tdata[125:121];
        seen.exponent        = out_tdata[140:126];
        seen.saturated       = out_tdata[141];
        seen.last            = out_tlast;
        if (expected_results.size() == 0) begin
          report_mismatch("beat with nothing outstanding, status", 64'(seen.status), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (seen.status !== want.status)
            report_mismatch("status", 64'(seen.status), 64'(want.status));
          if (seen.negative !== want.negative)
            report_mismatch("negative", 64'(seen.negative), 64'(want.negative));
          if (seen.integer_part !== want.integer_part)
            report_mismatch("integer_part", 64'(seen.integer_part), 64'(want.integer_part));
          if (seen.fraction_digits !== want.fraction_digits)
            report_mismatch("fraction_digits", 64'(seen.fraction_digits),
                            64'(want.fraction_digits));
          if (seen.fraction_length !== want.fraction_length)
            report_mismatch("fraction_length", 64'(seen.fraction_length),
                            64'(want.fraction_length));
          if (seen.exponent !== want.exponent)
            report_mismatch("exponent", 64'(unsigned'(seen.exponent)),
                            64'(unsigned'(want.exponent)));
          if (seen.saturated !== want.saturated)
            report_mismatch("saturated", 64'(seen.saturated), 64'(want.saturated));
          if (seen.last !== want.last)
            report_mismatch("last", 64'(seen.last), 64'(want.last));
        end
        results_checked++;
      end
      pending = expected_results.size();
    end
  end

endmodule

// ===== tb/decimal_number_literal_scanner_test.sv =====
// ----------------------------------------------------------------------------
// decimal_number_literal_scanner_test
// Drives character streams into the decimal number scanner: a directed set of
// literals and malformed forms, then random literals, noise and end-of-stream
// marks under several sender/receiver stall mixes, with a long output hold-off.
// ----------------------------------------------------------------------------
module decimal_number_literal_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dnls_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int PhaseItems  = 360;
  localparam int HoldCycles  = 300;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;
  logic         in_tuser   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  int fail_count;
  int pending;
  int results_checked;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int recv_hold      = 0;
  int beats_sent     = 0;
  int blanks_sent    = 0;
  int cycles         = 0;

  always #1 clk = ~clk;

  decimal_number_literal_scanner u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  dnls_result_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: long hold-off when requested, otherwise random stalls
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      out_tready <= 1'b0;
      recv_hold = recv_hold - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // valid stays up from one beat to the next unless a gap is drawn
  task automatic send_beat(input logic [7:0] ch, input logic eos);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_blank();
    int r;
    r = $urandom_range(0, 5);
    send_beat(8'((r == 5) ? CH_SP : CH_TAB + r), 1'b0);
    blanks_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic send_digits(input int count);
    logic nines;
    int   i;
    // runs of nines land exactly on the accumulator limits
    nines = ($urandom_range(0, 3) == 0);
    for (i = 0; i < count; i++)
      send_beat(nines ? CH_9 : 8'(CH_0 + $urandom_range(0, 9)), 1'b0);
  endtask

  function automatic int digit_run();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(17, 22);
    if (r < 3) return 0;
    return $urandom_range(1, 6);
  endfunction

  task automatic send_literal();
    int k;
    int r;
    for (k = $urandom_range(0, 2); k > 0; k--) send_blank();
    r = $urandom_range(0, 3);
    if (r == 1) send_beat(CH_PLUS, 1'b0);
    else if (r == 2) send_beat(CH_MINUS, 1'b0);
    send_digits(digit_run());
    if ($urandom_range(0, 1)) begin
      send_beat(CH_PT, 1'b0);
      send_digits(digit_run());
    end
    if ($urandom_range(0, 9) < 3) begin
      send_beat($urandom_range(0, 1) ? CH_E_LO : CH_E_UP, 1'b0);
      r = $urandom_range(0, 3);
      if (r == 1) send_beat(CH_PLUS, 1'b0);
      else if (r == 2) send_beat(CH_MINUS, 1'b0);
      send_digits(($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3));
    end
    r = $urandom_range(0, 9);
    if (r < 4) send_blank();
    else if (r < 6) send_beat(8'($urandom_range(0, 255)), 1'b1);
    else if (r < 9) send_beat(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic send_item_group();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      send_literal();
    end else if (r < 95) begin
      for (k = $urandom_range(1, 4); k > 0; k--)
        send_beat(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
    end else begin
      send_beat(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int ph;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full literal, bare point, bare sign then stray, empty fraction with exponent,
    // exponent sign with no digits, stray extremes, end of stream in idle
    send_text("-12.5E-7 ");
    send_text(". ");
    send_text("+x");
    send_text("5.e3,");
    send_text("1e+ ");
    send_beat(8'h00, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(8'hff, 1'b1);
    wait_all_results();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  recv_hold = HoldCycles; end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        3: begin send_idle_pct = 34; recv_stall_pct = 34; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      while (beats_sent < 25 + (ph + 1) * PhaseItems) send_item_group();
      wait_all_results();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d characters (%0d blanks) over five stall mixes incl. a long output hold-off;",
             beats_sent, blanks_sent);
    $display("checked %0d results, %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dnls_pkg.sv
rtl/core/dnls_scan.sv
rtl/core/dnls_resq.sv
rtl/core/decimal_number_literal_scanner.sv
tb/dnls_result_checker.sv
tb/decimal_number_literal_scanner_test.sv
